[rtl/motif_transform_classifier_assert.svh]
// Assertion macros shared by the motif transform classifier modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MOTIF_TRANSFORM_CLASSIFIER_ASSERT_SVH
`define MOTIF_TRANSFORM_CLASSIFIER_ASSERT_SVH

// Condition checked in the same cycle as the trigger.
`define MTC_CHECK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition checked in the cycle after the trigger.
`define MTC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mtc_pkg.sv]
// Shared types and codes of the motif transform classifier.
// No dependencies; every other RTL module imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

  localparam int PITCH_W = 7;
  localparam int KIND_W  = 3;
  localparam int OP_W    = 2;

  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [OP_W-1:0]    op_t;

  // Request opcodes.
  localparam op_t OP_LOAD_ORIG = 2'd0;
  localparam op_t OP_LOAD_CAND = 2'd1;
  localparam op_t OP_CLASSIFY  = 2'd2;

  // Result codes.
  localparam kind_t KIND_UNKNOWN        = 3'd0;
  localparam kind_t KIND_REPETITION     = 3'd1;
  localparam kind_t KIND_TRANSPOSITION  = 3'd2;
  localparam kind_t KIND_INVERSION      = 3'd3;
  localparam kind_t KIND_RETROGRADE     = 3'd4;
  localparam kind_t KIND_RETRO_INVERSION = 3'd5;
  localparam kind_t KIND_FRAGMENTATION  = 3'd6;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control that travels with each read of the note stores.
  typedef struct packed {
    logic step;       // read data of one note position arrives this cycle
    logic first;      // that position is the first one
    logic equal_len;  // both sequences have the same length
  } walk_ctl_t;

endpackage

`default_nettype wire

[rtl/mtc_note_store.sv]
// Note memories of the classifier: original and candidate pitches, fill counts
// and the dropped-note flag. Depends on mtc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "motif_transform_classifier_assert.svh"

module mtc_note_store
  import mtc_pkg::*;
#(
  parameter int MAX_NOTES = 64,
  localparam int ADDR_W = $clog2(MAX_NOTES),
  localparam int CNT_W  = $clog2(MAX_NOTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_en,
  input  wire logic              load_cand,
  input  wire pitch_t            load_pitch,
  input  wire logic              clear,
  input  wire logic [ADDR_W-1:0] orig_addr_a,
  input  wire logic [ADDR_W-1:0] orig_addr_b,
  input  wire logic [ADDR_W-1:0] cand_addr,
  output pitch_t                 orig_data_a,
  output pitch_t                 orig_data_b,
  output pitch_t                 cand_data,
  output logic [CNT_W-1:0]       orig_count,
  output logic [CNT_W-1:0]       cand_count,
  output logic                   dropped
);

  pitch_t orig_mem [MAX_NOTES];
  pitch_t cand_mem [MAX_NOTES];

  logic orig_room;
  logic cand_room;
  logic orig_wr;
  logic cand_wr;

  assign orig_room = orig_count < CNT_W'(MAX_NOTES);
  assign cand_room = cand_count < CNT_W'(MAX_NOTES);
  assign orig_wr   = load_en && !load_cand && orig_room;
  assign cand_wr   = load_en && load_cand && cand_room;

  // Fill counts and the dropped flag; classify clears all three.
  always_ff @(posedge clk) begin
    if (rst) begin
      orig_count <= '0;
      cand_count <= '0;
      dropped    <= 1'b0;
    end else if (clear) begin
      orig_count <= '0;
      cand_count <= '0;
      dropped    <= 1'b0;
    end else if (load_en) begin
      if (orig_wr) begin
        orig_count <= orig_count + CNT_W'(1);
      end else if (cand_wr) begin
        cand_count <= cand_count + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // Appends go to the slot just past the last stored note.
  always_ff @(posedge clk) begin
    if (orig_wr) begin
      orig_mem[orig_count[ADDR_W-1:0]] <= load_pitch;
    end
    if (cand_wr) begin
      cand_mem[cand_count[ADDR_W-1:0]] <= load_pitch;
    end
  end

  // Registered reads: two ports on the original, one on the candidate.
  always_ff @(posedge clk) begin
    orig_data_a <= orig_mem[orig_addr_a];
    orig_data_b <= orig_mem[orig_addr_b];
    cand_data   <= cand_mem[cand_addr];
  end

  `MTC_CHECK_NEXT(a_clear_empties, clear,
    (orig_count == '0) && (cand_count == '0) && !dropped,
    "classify did not empty the note stores")
  `MTC_CHECK_NEXT(a_full_drops, load_en && !load_cand && !orig_room,
    dropped && (orig_count == CNT_W'(MAX_NOTES)),
    "note appended to a full original store was not flagged")

endmodule

`default_nettype wire

[rtl/mtc_match_core.sv]
// Per-note comparison of the classifier: keeps one match flag per relationship
// while the sequencer streams note positions. Depends on mtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtc_match_core
  import mtc_pkg::*;
(
  input  wire logic      clk,
  input  wire walk_ctl_t ctl,
  input  wire pitch_t    orig_a,
  input  wire pitch_t    orig_b,
  input  wire pitch_t    cand,
  output kind_t          kind
);

  // Mirror p about axis, clamped to the pitch range.
  function automatic pitch_t mirror(input pitch_t axis, input pitch_t p);
    logic signed [PITCH_W+2:0] v;
    begin
      v = $signed({2'b00, axis, 1'b0}) - $signed({3'b000, p});
      if (v < 0) begin
        mirror = '0;
      end else if (v > $signed((PITCH_W+3)'(127))) begin
        mirror = pitch_t'(127);
      end else begin
        mirror = v[PITCH_W-1:0];
      end
    end
  endfunction

  function automatic logic [PITCH_W:0] add(input pitch_t a, input pitch_t b);
    add = {1'b0, a} + {1'b0, b};
  endfunction

  pitch_t first_q;
  pitch_t last_q;
  pitch_t c0_q;
  pitch_t first_ax;
  pitch_t last_ax;
  pitch_t c0;

  logic rep, trn, inv, ret, ri, suf;
  logic hit_rep, hit_trn, hit_inv, hit_ret, hit_ri, hit_suf;

  // Axes and the candidate's first note come from the first position.
  assign first_ax = ctl.first ? orig_a : first_q;
  assign last_ax  = ctl.first ? orig_b : last_q;
  assign c0       = ctl.first ? cand   : c0_q;

  // Offsets are compared as sums so that no signed difference is needed.
  assign hit_rep = cand == orig_a;
  assign hit_suf = cand == orig_b;
  assign hit_trn = add(cand, first_ax) == add(orig_a, c0);
  assign hit_inv = add(cand, first_ax) == add(mirror(first_ax, orig_a), c0);
  assign hit_ret = add(cand, last_ax) == add(orig_b, c0);
  assign hit_ri  = add(cand, last_ax) == add(mirror(last_ax, orig_b), c0);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.first) begin
        first_q <= orig_a;
        last_q  <= orig_b;
        c0_q    <= cand;
      end
      rep <= hit_rep && (ctl.first || rep);
      trn <= hit_trn && (ctl.first || trn);
      inv <= hit_inv && (ctl.first || inv);
      ret <= hit_ret && (ctl.first || ret);
      ri  <= hit_ri  && (ctl.first || ri);
      suf <= hit_suf && (ctl.first || suf);
    end
  end

  // Priority order of the relationships.
  always_comb begin
    kind = KIND_UNKNOWN;
    if (ctl.equal_len) begin
      if (rep) begin
        kind = KIND_REPETITION;
      end else if (trn) begin
        kind = KIND_TRANSPOSITION;
      end else if (inv) begin
        kind = KIND_INVERSION;
      end else if (ret) begin
        kind = KIND_RETROGRADE;
      end else if (ri) begin
        kind = KIND_RETRO_INVERSION;
      end
    end else if (rep || suf) begin
      kind = KIND_FRAGMENTATION;
    end
  end

endmodule

`default_nettype wire

[rtl/motif_transform_classifier.sv]
// Motif transform classifier: the request channel appends notes or asks for a
// classification, and the result channel returns its relationship code.
// How to use it:
//   s_tvalid/s_tready/s_tuser/s_tdata carry requests. s_tuser is the opcode:
//   append to the original, append to the candidate, or classify and clear.
//   m_tvalid/m_tready/m_tdata carry one result for each classify request.
//   An append gives no result; a note that finds its store full is dropped
//   and reported with the next result as overflowed.
//   A classify request goes straight to the finishing state when either store is
//   empty or the candidate is the longer one; otherwise the walk reads one note
//   position per cycle, using two read ports on the original memory and one on
//   the candidate memory, and a drain state follows it. Requests are held off
//   until the result register takes the result.
//   Reset empties both stores and clears the flag; the memories are not cleared.
//   A stalled result stays in the output register; a later classify then waits
//   in its finishing state and accepts no request until the register frees.
// Depends on mtc_pkg, mtc_note_store, mtc_match_core and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "motif_transform_classifier_assert.svh"

module motif_transform_classifier
  import mtc_pkg::*;
#(
  parameter int MAX_NOTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [1:0] s_tuser,   // [1:0] op
  input  wire logic [7:0] s_tdata,   // [6:0] pitch, [7] zero
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [2:0] kind, [3] overflowed, [7:4] zero
);

  localparam int ADDR_W = $clog2(MAX_NOTES);
  localparam int CNT_W  = $clog2(MAX_NOTES + 1);

  state_t state;
  state_t state_next;

  logic              accept;
  logic              load_en;
  logic              load_cand;
  logic              classify_go;
  logic              trivial_now;
  logic              issue;
  logic              out_free;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  len_n;
  logic [CNT_W-1:0]  len_m;
  logic [CNT_W-1:0]  addr_b_full;
  logic              equal_len;
  logic              trivial;
  logic              drop_snap;
  walk_ctl_t         ctl;
  kind_t             match_kind;
  kind_t             kind_q;
  logic              ovf_q;

  pitch_t            orig_a;
  pitch_t            orig_b;
  pitch_t            cand;
  logic [CNT_W-1:0]  orig_count;
  logic [CNT_W-1:0]  cand_count;
  logic              dropped;

  // Request decode.
  assign s_tready    = state == ST_IDLE;
  assign accept      = s_tvalid && s_tready;
  assign load_en     = accept && (s_tuser == OP_LOAD_ORIG || s_tuser == OP_LOAD_CAND);
  assign load_cand   = s_tuser == OP_LOAD_CAND;
  assign classify_go = accept && (s_tuser == OP_CLASSIFY);
  assign trivial_now = (orig_count == '0) || (cand_count == '0) ||
                       (cand_count > orig_count);
  assign out_free    = !m_tvalid || m_tready;

  // Second original port: mirrored position for equal lengths, tail otherwise.
  assign idx_ext     = CNT_W'(idx);
  assign addr_b_full = equal_len ? (len_n - CNT_W'(1) - idx_ext)
                                 : (len_n - len_m + idx_ext);

  mtc_note_store #(
    .MAX_NOTES (MAX_NOTES)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .load_en     (load_en),
    .load_cand   (load_cand),
    .load_pitch  (s_tdata[PITCH_W-1:0]),
    .clear       (classify_go),
    .orig_addr_a (idx),
    .orig_addr_b (addr_b_full[ADDR_W-1:0]),
    .cand_addr   (idx),
    .orig_data_a (orig_a),
    .orig_data_b (orig_b),
    .cand_data   (cand),
    .orig_count  (orig_count),
    .cand_count  (cand_count),
    .dropped     (dropped)
  );

  mtc_match_core u_match (
    .clk    (clk),
    .ctl    (ctl),
    .orig_a (orig_a),
    .orig_b (orig_b),
    .cand   (cand),
    .kind   (match_kind)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and read issue.
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (classify_go) begin
          state_next = trivial_now ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        issue = 1'b1;
        if (idx_ext == len_m - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Snapshot of the stores taken as classify clears them.
  always_ff @(posedge clk) begin
    if (classify_go) begin
      len_n     <= orig_count;
      len_m     <= cand_count;
      equal_len <= orig_count == cand_count;
      trivial   <= trivial_now;
      drop_snap <= dropped;
      idx       <= '0;
    end else if (issue) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // Control that lines up with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.step      <= issue;
      ctl.first     <= idx == '0;
      ctl.equal_len <= equal_len;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      kind_q <= trivial ? KIND_UNKNOWN : match_kind;
      ovf_q  <= drop_snap;
    end
  end

  assign m_tdata = {4'b0000, ovf_q, kind_q};

  `MTC_CHECK_SAME(a_walk_in_range, state == ST_WALK,
    (idx_ext < len_m) && (len_m <= len_n),
    "note walk ran past the candidate length")
  `MTC_CHECK_SAME(a_result_from_done, $rose(m_tvalid),
    $past(state) == ST_DONE,
    "result presented outside the finishing state")

endmodule

`default_nettype wire

[sim/tb_motif_transform_classifier.sv]
`timescale 1ns / 1ps
// Self-checking testbench for motif_transform_classifier: loads note sequences,
// issues classify requests and compares every result with an in-bench predictor.
// Depends on mtc_pkg and the motif_transform_classifier RTL.

module tb_motif_transform_classifier;
  import mtc_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int PITCH_MAX = 127;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS = 300;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    kind_t kind;
    logic  overflowed;
  } verdict_t;

  // Shapes of candidate that the random part derives from an original.
  typedef enum int {
    SHAPE_REPEAT,
    SHAPE_SHIFT,
    SHAPE_INVERT,
    SHAPE_REVERSE,
    SHAPE_REVERSE_INVERT,
    SHAPE_FRAGMENT,
    SHAPE_RANDOM
  } shape_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [1:0] s_tuser = OP_LOAD_ORIG;   // [1:0] op
  logic [7:0] s_tdata = 8'd0;           // [6:0] pitch, [7] zero
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;                  // [2:0] kind, [3] overflowed, [7:4] zero

  // Predictor state.
  pitch_t   orig_notes [STORE_DEPTH];
  pitch_t   cand_notes [STORE_DEPTH];
  int       orig_len = 0;
  int       cand_len = 0;
  bit       notes_dropped = 1'b0;
  verdict_t pending_verdicts [$];

  int fail_count = 0;
  int result_count = 0;
  int request_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  motif_transform_classifier #(
    .MAX_NOTES(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a value into the pitch range.
  function automatic pitch_t fit_pitch(int v);
    if (v < 0) return pitch_t'(0);
    if (v > PITCH_MAX) return pitch_t'(PITCH_MAX);
    return pitch_t'(v);
  endfunction

  // Mirror a pitch about an axis, clamped into the pitch range.
  function automatic int reflect_clamp(int axis, int p);
    return int'(fit_pitch(2 * axis - p));
  endfunction

  // Relationship of the stored candidate to the stored original.
  function automatic kind_t classify_motif();
    int n, m, first_axis, last_axis, d_shift, d_inv, d_rev, d_rev_inv, c, o, r;
    bit rep, shifted, inv, rev, rev_inv, prefix, suffix;
    n = orig_len;
    m = cand_len;
    if (n == 0 || m == 0 || m > n) return KIND_UNKNOWN;
    // Unequal lengths can only be a fragment taken from either end.
    if (n != m) begin
      prefix = 1'b1;
      suffix = 1'b1;
      for (int i = 0; i < m; i++) begin
        if (cand_notes[i] != orig_notes[i]) prefix = 1'b0;
        if (cand_notes[i] != orig_notes[n - m + i]) suffix = 1'b0;
      end
      return (prefix || suffix) ? KIND_FRAGMENTATION : KIND_UNKNOWN;
    end
    first_axis = orig_notes[0];
    last_axis = orig_notes[n - 1];
    d_shift = int'(cand_notes[0]) - first_axis;
    d_inv = int'(cand_notes[0]) - reflect_clamp(first_axis, first_axis);
    d_rev = int'(cand_notes[0]) - last_axis;
    d_rev_inv = int'(cand_notes[0]) - reflect_clamp(last_axis, last_axis);
    rep = 1'b1;
    shifted = 1'b1;
    inv = 1'b1;
    rev = 1'b1;
    rev_inv = 1'b1;
    for (int i = 0; i < n; i++) begin
      c = cand_notes[i];
      o = orig_notes[i];
      r = orig_notes[n - 1 - i];
      if (c != o) rep = 1'b0;
      if (c - o != d_shift) shifted = 1'b0;
      if (c != reflect_clamp(first_axis, o) + d_inv) inv = 1'b0;
      if (c - r != d_rev) rev = 1'b0;
      if (c - reflect_clamp(last_axis, r) != d_rev_inv) rev_inv = 1'b0;
    end
    if (rep) return KIND_REPETITION;
    if (shifted) return KIND_TRANSPOSITION;
    if (inv) return KIND_INVERSION;
    if (rev) return KIND_RETROGRADE;
    if (rev_inv) return KIND_RETRO_INVERSION;
    return KIND_UNKNOWN;
  endfunction

  // Update the predictor with one accepted request.
  function automatic void apply_request(op_t op, pitch_t pitch);
    verdict_t v;
    case (op)
      OP_LOAD_ORIG: begin
        if (orig_len < STORE_DEPTH) begin
          orig_notes[orig_len] = pitch;
          orig_len++;
        end else begin
          notes_dropped = 1'b1;
        end
      end
      OP_LOAD_CAND: begin
        if (cand_len < STORE_DEPTH) begin
          cand_notes[cand_len] = pitch;
          cand_len++;
        end else begin
          notes_dropped = 1'b1;
        end
      end
      OP_CLASSIFY: begin
        v.kind = classify_motif();
        v.overflowed = notes_dropped;
        pending_verdicts = {pending_verdicts, v};
        orig_len = 0;
        cand_len = 0;
        notes_dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  // Send one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_request(input op_t op, input pitch_t pitch);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, pitch};
    do begin
      @(posedge clk);
    end while (!s_tready);
    apply_request(op, pitch);
    if (op != OP_UNUSED) request_count++;
  endtask

  // Results are taken in, and the receiver stalls at random, on each rising edge.
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (pending_verdicts.size() == 0) begin
          note_failure($sformatf("result %0d arrived with none expected: kind %0d overflowed %0b",
                                 result_count, m_tdata[2:0], m_tdata[3]));
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[2:0] !== want.kind || m_tdata[3] !== want.overflowed)
            note_failure($sformatf(
                "result %0d: kind expected %0d got %0d, overflowed expected %0b got %0b",
                result_count, want.kind, m_tdata[2:0], want.overflowed, m_tdata[3]));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // The run ends if neither channel moves a request or result for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Empty stores, an ignored opcode and an original with no candidate.
  task automatic test_empty_stores();
    send_request(OP_CLASSIFY, 7'd127);
    send_request(OP_UNUSED, 7'd127);
    send_request(OP_LOAD_ORIG, 7'd5);
    send_request(OP_CLASSIFY, 7'd0);
  endtask

  task automatic test_repetition_extremes();
    send_request(OP_LOAD_ORIG, 7'd0);
    send_request(OP_LOAD_ORIG, 7'd127);
    send_request(OP_LOAD_CAND, 7'd0);
    send_request(OP_LOAD_CAND, 7'd127);
    send_request(OP_CLASSIFY, 7'd85);
  endtask

  task automatic test_transposition();
    send_request(OP_LOAD_ORIG, 7'd0);
    send_request(OP_LOAD_ORIG, 7'd2);
    send_request(OP_LOAD_CAND, 7'd125);
    send_request(OP_LOAD_CAND, 7'd127);
    send_request(OP_CLASSIFY, 7'd42);
  endtask

  // The mirrored second note clamps at the top of the range before the offset.
  task automatic test_clamped_inversion();
    send_request(OP_LOAD_ORIG, 7'd100);
    send_request(OP_LOAD_ORIG, 7'd10);
    send_request(OP_LOAD_CAND, 7'd90);
    send_request(OP_LOAD_CAND, 7'd117);
    send_request(OP_CLASSIFY, 7'd0);
  endtask

  task automatic test_retrograde();
    send_request(OP_LOAD_ORIG, 7'd1);
    send_request(OP_LOAD_ORIG, 7'd2);
    send_request(OP_LOAD_ORIG, 7'd4);
    send_request(OP_LOAD_CAND, 7'd4);
    send_request(OP_LOAD_CAND, 7'd2);
    send_request(OP_LOAD_CAND, 7'd1);
    send_request(OP_CLASSIFY, 7'd0);
  endtask

  task automatic test_retro_inversion();
    send_request(OP_LOAD_ORIG, 7'd10);
    send_request(OP_LOAD_ORIG, 7'd12);
    send_request(OP_LOAD_ORIG, 7'd15);
    send_request(OP_LOAD_CAND, 7'd20);
    send_request(OP_LOAD_CAND, 7'd23);
    send_request(OP_LOAD_CAND, 7'd25);
    send_request(OP_CLASSIFY, 7'd0);
  endtask

  task automatic test_fragment_prefix();
    send_request(OP_LOAD_ORIG, 7'd127);
    send_request(OP_LOAD_ORIG, 7'd0);
    send_request(OP_LOAD_CAND, 7'd127);
    send_request(OP_CLASSIFY, 7'd0);
  endtask

  task automatic test_longer_candidate();
    send_request(OP_LOAD_ORIG, 7'd1);
    send_request(OP_LOAD_CAND, 7'd1);
    send_request(OP_LOAD_CAND, 7'd1);
    send_request(OP_CLASSIFY, 7'd0);
  endtask

  // One original and a candidate derived from it, loaded interleaved, then
  // usually a classify. Now and then a long original overfills a store.
  task automatic send_random_motif();
    pitch_t base [$];
    pitch_t derived [$];
    int n, m, start, shift;
    bit wide;
    shape_t shape;
    if ($urandom_range(0, 11) == 0) n = $urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 4);
    else n = $urandom_range(1, 8);
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      base = {base, (wide ? pitch_t'($urandom_range(0, PITCH_MAX))
                          : pitch_t'($urandom_range(40, 88)))};
    shape = shape_t'($urandom_range(0, 6));
    shift = int'($urandom_range(0, 40)) - 20;
    case (shape)
      SHAPE_REPEAT:
        for (int i = 0; i < n; i++) derived = {derived, base[i]};
      SHAPE_SHIFT:
        for (int i = 0; i < n; i++) derived = {derived, fit_pitch(base[i] + shift)};
      SHAPE_INVERT:
        for (int i = 0; i < n; i++)
          derived = {derived, fit_pitch(reflect_clamp(base[0], base[i]) + shift)};
      SHAPE_REVERSE:
        for (int i = 0; i < n; i++) derived = {derived, fit_pitch(base[n - 1 - i] + shift)};
      SHAPE_REVERSE_INVERT:
        for (int i = 0; i < n; i++)
          derived = {derived, fit_pitch(reflect_clamp(base[n - 1], base[n - 1 - i]) + shift)};
      SHAPE_FRAGMENT: begin
        m = $urandom_range(1, n);
        start = $urandom_range(0, 1) ? 0 : n - m;
        for (int i = 0; i < m; i++) derived = {derived, base[start + i]};
      end
      default: begin
        m = $urandom_range(0, n + 2);
        for (int i = 0; i < m; i++)
          derived = {derived, pitch_t'($urandom_range(0, PITCH_MAX))};
      end
    endcase
    // Break the relationship now and then.
    if (derived.size() > 0 && $urandom_range(0, 7) == 0)
      derived[$urandom_range(0, derived.size() - 1)] = pitch_t'($urandom_range(0, PITCH_MAX));
    while (base.size() + derived.size() > 0) begin
      if ($urandom_range(0, 19) == 0) send_request(OP_UNUSED, pitch_t'($urandom_range(0, PITCH_MAX)));
      if (derived.size() == 0 || (base.size() > 0 && $urandom_range(0, 1)))
        send_request(OP_LOAD_ORIG, base.pop_front());
      else
        send_request(OP_LOAD_CAND, derived.pop_front());
    end
    if ($urandom_range(0, 15) != 0) send_request(OP_CLASSIFY, pitch_t'($urandom_range(0, PITCH_MAX)));
  endtask

  task automatic test_random_phase(input int sender_pct, input int receiver_pct);
    int goal;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    goal = request_count + PHASE_ITEMS;
    while (request_count < goal) send_random_motif();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_stores();
    test_repetition_extremes();
    test_transposition();
    test_clamped_inversion();
    test_retrograde();
    test_retro_inversion();
    test_fragment_prefix();
    test_longer_candidate();

    test_random_phase(0, 0);
    test_random_phase(46, 0);
    test_random_phase(0, 46);
    test_random_phase(12, 12);

    // Let every outstanding classify finish, then watch for stray results.
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
